@@ rtl/core/lightgun_pad_responder_top_assert.svh @@
// Assertion macros for the light-gun pad responder.
// Used by lgpr_back; expects clk_i and rst_ni in scope.
`ifndef LIGHTGUN_PAD_RESPONDER_TOP_ASSERT_SVH
`define LIGHTGUN_PAD_RESPONDER_TOP_ASSERT_SVH

// same-cycle implication
`define LGPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LGPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lgpr_pkg.sv @@
// Package for the light-gun pad responder: item types, reply type, codes.
// No dependencies.
package lgpr_pkg;

  localparam int unsigned REPLY_LEN = 9;
  localparam int unsigned IDX_W     = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLY_LEN - 1);

  localparam logic [1:0] KIND_TRANSFER = 2'd0;
  localparam logic [1:0] KIND_PRESS    = 2'd1;
  localparam logic [1:0] KIND_RELEASE  = 2'd2;
  localparam logic [1:0] KIND_AXIS     = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  localparam logic [7:0] CB_INIT_PRESS = 8'h40;
  localparam logic [7:0] CB_QUERY_MASK = 8'h41;
  localparam logic [7:0] CB_READ_DATA  = 8'h42;
  localparam logic [7:0] CB_CONFIG     = 8'h43;
  localparam logic [7:0] CB_SET_MODE   = 8'h44;
  localparam logic [7:0] CB_QUERY_MODEL= 8'h45;
  localparam logic [7:0] CB_QUERY_ACT  = 8'h46;
  localparam logic [7:0] CB_QUERY_COMB = 8'h47;
  localparam logic [7:0] CB_QUERY_MODE = 8'h4C;
  localparam logic [7:0] CB_VIB_MAP    = 8'h4D;
  localparam logic [7:0] CB_PRES_CFG   = 8'h4F;

  localparam logic [15:0] BUTTON_RESET = 16'hffff;
  localparam logic [15:0] AIM_X_RESET  = 16'h010d;
  localparam logic [15:0] AIM_Y_RESET  = 16'h0088;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  command_byte;
    logic [7:0]  param_byte;
    logic [15:0] button_mask;
    logic [1:0]  axis_select;
    logic [7:0]  axis_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       bad_command;
  } out_item_t;

  typedef struct packed {
    logic [REPLY_LEN-1:0][7:0] bytes;
    logic                      bad;
  } reply_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/core/lgpr_front.sv @@
// Front end: accepts items, updates button/aim/config state, builds replies.
// Depends on lgpr_pkg.
module lgpr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  lgpr_pkg::in_item_t in_item_i,
  input  lgpr_pkg::q_stat_t q_stat_i,
  output logic              q_push_o,
  output lgpr_pkg::reply_t  q_data_o
);
  import lgpr_pkg::*;

  logic [15:0] button_q, button_d;
  logic [15:0] aim_x_q, aim_x_d;
  logic [15:0] aim_y_q, aim_y_d;
  logic        cfg_q, cfg_d;
  logic        accept;
  reply_t      blank, live, rep;
  logic        arg_nz;

  assign full   = q_stat_i.full;
  assign accept = push && !q_stat_i.full;
  assign arg_nz = (in_item_i.param_byte != 8'h00);

  always_comb begin
    blank       = '0;
    blank.bytes[0] = 8'hff;
    blank.bytes[1] = 8'hf3;
    blank.bytes[2] = 8'h5a;
    live        = '0;
    live.bytes[0] = 8'hff;
    live.bytes[1] = 8'h63;
    live.bytes[2] = 8'h5a;
    live.bytes[3] = button_q[7:0];
    live.bytes[4] = button_q[15:8];
    live.bytes[5] = aim_x_q[7:0];
    live.bytes[6] = aim_x_q[15:8];
    live.bytes[7] = aim_y_q[7:0];
    live.bytes[8] = aim_y_q[15:8];

    rep = blank;
    case (in_item_i.command_byte)
      CB_INIT_PRESS: begin
        rep.bytes[5] = 8'h02;
        rep.bytes[8] = 8'h5a;
      end
      CB_QUERY_MASK, CB_SET_MODE: rep = blank;
      CB_READ_DATA: rep = live;
      CB_CONFIG: rep = cfg_q ? blank : live;
      CB_QUERY_MODEL: begin
        rep.bytes[3] = 8'h03;
        rep.bytes[4] = 8'h02;
        rep.bytes[6] = 8'h02;
        rep.bytes[7] = 8'h01;
      end
      CB_QUERY_ACT: begin
        rep.bytes[5] = 8'h01;
        if (arg_nz) begin
          rep.bytes[6] = 8'h01;
          rep.bytes[7] = 8'h01;
          rep.bytes[8] = 8'h14;
        end else begin
          rep.bytes[6] = 8'h02;
          rep.bytes[8] = 8'h0a;
        end
      end
      CB_QUERY_COMB: begin
        rep.bytes[5] = 8'h02;
        rep.bytes[7] = 8'h01;
      end
      CB_QUERY_MODE: rep.bytes[6] = arg_nz ? 8'h07 : 8'h04;
      CB_VIB_MAP: begin
        rep.bytes[5] = 8'hff;
        rep.bytes[6] = 8'hff;
        rep.bytes[7] = 8'hff;
        rep.bytes[8] = 8'hff;
      end
      CB_PRES_CFG: rep.bytes[8] = 8'h5a;
      default: begin
        rep     = '0;
        rep.bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    button_d = button_q;
    aim_x_d  = aim_x_q;
    aim_y_d  = aim_y_q;
    cfg_d    = cfg_q;
    if (accept) begin
      case (in_item_i.cmd)
        KIND_TRANSFER: begin
          if (in_item_i.command_byte == CB_CONFIG) cfg_d = arg_nz;
        end
        KIND_PRESS:   button_d = button_q & ~in_item_i.button_mask;
        KIND_RELEASE: button_d = button_q | in_item_i.button_mask;
        KIND_AXIS: begin
          if (in_item_i.axis_select == AXIS_X) aim_x_d = {8'h00, in_item_i.axis_value};
          else if (in_item_i.axis_select == AXIS_Y) aim_y_d = {8'h00, in_item_i.axis_value};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_q <= BUTTON_RESET;
      aim_x_q  <= AIM_X_RESET;
      aim_y_q  <= AIM_Y_RESET;
      cfg_q    <= 1'b0;
    end else begin
      button_q <= button_d;
      aim_x_q  <= aim_x_d;
      aim_y_q  <= aim_y_d;
      cfg_q    <= cfg_d;
    end
  end

  assign q_push_o = accept && (in_item_i.cmd == KIND_TRANSFER);
  assign q_data_o = rep;

endmodule

@@ rtl/core/lgpr_queue.sv @@
// Two-entry reply queue between front and back end.
// Depends on lgpr_pkg.
module lgpr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lgpr_pkg::reply_t  wdata_i,
  input  logic              pop_i,
  output lgpr_pkg::reply_t  rdata_o,
  output lgpr_pkg::q_stat_t stat_o
);
  import lgpr_pkg::*;

  reply_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/lgpr_back.sv @@
// Back end: holds the current reply and sends it out one byte per item.
// Depends on lgpr_pkg and lightgun_pad_responder_top_assert.svh.
module lgpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lgpr_pkg::q_stat_t  q_stat_i,
  input  lgpr_pkg::reply_t   q_data_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output lgpr_pkg::out_item_t out_item_o
);
  import lgpr_pkg::*;
  `include "lightgun_pad_responder_top_assert.svh"

  reply_t           cur_q, cur_d;
  logic             valid_q, valid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             fire, is_last, load;

  assign is_last = cur_q.bad || (idx_q == LAST_IDX);
  assign fire    = pop && valid_q;
  assign load    = (!valid_q || (fire && is_last)) && !q_stat_i.empty;
  assign q_pop_o = load;

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      cur_d   = q_data_i;
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (is_last) valid_d = 1'b0;
      else idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  assign empty                  = !valid_q;
  assign out_item_o.data_byte   = cur_q.bytes[idx_q];
  assign out_item_o.last_byte   = is_last;
  assign out_item_o.bad_command = cur_q.bad;

  `LGPR_ASSERT_NOW(a_idx_range, valid_q, idx_q <= LAST_IDX, "byte index out of range")
  `LGPR_ASSERT_NOW(a_bad_single, valid_q && cur_q.bad, idx_q == '0, "error reply past first item")
  `LGPR_ASSERT_NEXT(a_stall_hold, valid_q && !pop, valid_q && $stable(idx_q), "stalled reply moved")

endmodule

@@ rtl/core/lightgun_pad_responder_top.sv @@
// Light-gun pad responder, device side of a serial pad command protocol.
// Queue-style input (push/full) and result (empty/pop) channels.
// Input items: transfers (command byte + argument) produce a nine-item
// reply, the ninth marked by last_byte; an unhandled command byte produces
// one item with bad_command and last_byte set. Press, release and axis
// items update the button word or aim values and produce no result.
// State updates and reply contents are fixed when the item is accepted.
// When the back end is free, a reply is written into the reply queue and is
// then loaded into the back end's current-reply register, from which its first
// item can be taken. The back end sends one reply item per cycle while the
// receiver pops; state items are taken one per cycle while the two-entry reply
// queue has room.
// When the receiver stalls, the current item holds; full rises once two
// replies wait behind the one being sent.
// Reset: buttons all released (0xffff), aim X 0x010d, aim Y 0x0088,
// config mode off, queue and output empty.
// Depends on lgpr_pkg, lgpr_front, lgpr_queue, lgpr_back.
module lightgun_pad_responder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  lgpr_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output lgpr_pkg::out_item_t out_item_o
);
  import lgpr_pkg::*;

  q_stat_t q_stat;
  reply_t  q_wdata, q_rdata;
  logic    q_push, q_pop;

  lgpr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  lgpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  lgpr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

@@ tb/sv/tb_lightgun_pad_responder_top.sv @@
// Testbench for lightgun_pad_responder_top: directed table plus random items,
// with reply bytes checked against a behavioral predictor of the pad state.
// Depends on lgpr_pkg and the responder RTL.
`timescale 1ns / 100ps

module tb_lightgun_pad_responder_top;
  import lgpr_pkg::*;

  localparam logic [71:0] BLANK_REPLY = 72'hff_f3_5a_00_00_00_00_00_00;
  localparam int IN_W = $bits(in_item_t);

  typedef struct {
    in_item_t item;
    bit       typed;
    reply_t   rep;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  logic [15:0] btn_word;
  logic [15:0] aim_x;
  logic [15:0] aim_y;
  logic        cfg_mode;

  out_item_t   pending_bytes[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  handled_cb[11];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_cycles;

  lightgun_pad_responder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic reply_t to_reply(input logic [71:0] h, input logic bad);
    reply_t r;
    for (int i = 0; i < REPLY_LEN; i++) r.bytes[i] = h[71-8*i -: 8];
    r.bad = bad;
    return r;
  endfunction

  // returns 1 when the item produces a reply; updates the pad state
  function automatic bit compute_reply(input in_item_t it, output reply_t rep);
    reply_t live;
    live = to_reply({8'hff, 8'h63, 8'h5a, btn_word[7:0], btn_word[15:8],
                     aim_x[7:0], aim_x[15:8], aim_y[7:0], aim_y[15:8]}, 1'b0);
    rep = to_reply(BLANK_REPLY, 1'b0);
    case (it.cmd)
      KIND_PRESS: begin
        btn_word = btn_word & ~it.button_mask;
        return 1'b0;
      end
      KIND_RELEASE: begin
        btn_word = btn_word | it.button_mask;
        return 1'b0;
      end
      KIND_AXIS: begin
        if (it.axis_select == AXIS_X) aim_x = {8'h00, it.axis_value};
        else if (it.axis_select == AXIS_Y) aim_y = {8'h00, it.axis_value};
        return 1'b0;
      end
      default: ;
    endcase
    case (it.command_byte)
      CB_INIT_PRESS:  rep = to_reply(72'hff_f3_5a_00_00_02_00_00_5a, 1'b0);
      CB_QUERY_MASK,
      CB_SET_MODE:    rep = to_reply(BLANK_REPLY, 1'b0);
      CB_QUERY_MODEL: rep = to_reply(72'hff_f3_5a_03_02_00_02_01_00, 1'b0);
      CB_QUERY_COMB:  rep = to_reply(72'hff_f3_5a_00_00_02_00_01_00, 1'b0);
      CB_VIB_MAP:     rep = to_reply(72'hff_f3_5a_00_00_ff_ff_ff_ff, 1'b0);
      CB_PRES_CFG:    rep = to_reply(72'hff_f3_5a_00_00_00_00_00_5a, 1'b0);
      CB_READ_DATA:   rep = live;
      CB_CONFIG: begin
        rep = cfg_mode ? to_reply(BLANK_REPLY, 1'b0) : live;
        cfg_mode = (it.param_byte != 8'h00);
      end
      CB_QUERY_ACT: begin
        if (it.param_byte != 8'h00) rep = to_reply(72'hff_f3_5a_00_00_01_01_01_14, 1'b0);
        else rep = to_reply(72'hff_f3_5a_00_00_01_02_00_0a, 1'b0);
      end
      CB_QUERY_MODE: rep.bytes[6] = (it.param_byte != 8'h00) ? 8'h07 : 8'h04;
      default: rep.bad = 1'b1;
    endcase
    return 1'b1;
  endfunction

  function automatic void add_row(input logic [1:0] kind, input logic [7:0] cb,
                                  input logic [7:0] arg, input logic [15:0] mask,
                                  input logic [1:0] ax, input logic [7:0] val,
                                  input bit typed, input logic bad,
                                  input logic [71:0] hex);
    dir_row_t r;
    r.item.cmd          = kind;
    r.item.command_byte = cb;
    r.item.param_byte   = arg;
    r.item.button_mask  = mask;
    r.item.axis_select  = ax;
    r.item.axis_value   = val;
    r.typed             = typed;
    r.rep               = to_reply(hex, bad);
    dir_tab.push_back(r);
  endfunction

  // offer one item, wait for it to be taken, then queue its reply bytes
  task automatic send_item(input in_item_t it, input bit typed, input reply_t typed_rep);
    reply_t    rep;
    out_item_t e;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    if (compute_reply(it, rep)) begin
      if (typed) rep = typed_rep;
      if (rep.bad) begin
        e.data_byte   = 8'h00;
        e.last_byte   = 1'b1;
        e.bad_command = 1'b1;
        pending_bytes.push_back(e);
      end else begin
        for (int i = 0; i < REPLY_LEN; i++) begin
          e.data_byte   = rep.bytes[i];
          e.last_byte   = (i == REPLY_LEN - 1);
          e.bad_command = 1'b0;
          pending_bytes.push_back(e);
        end
      end
    end
  endtask

  task automatic run_random(input int n);
    in_item_t it;
    int       pick;
    for (int k = 0; k < n; k++) begin
      it   = in_item_t'(IN_W'({$urandom, $urandom}));
      pick = $urandom_range(99);
      if (pick < 55) it.cmd = KIND_TRANSFER;
      else if (pick < 70) it.cmd = KIND_PRESS;
      else if (pick < 85) it.cmd = KIND_RELEASE;
      else it.cmd = KIND_AXIS;
      if ($urandom_range(6) != 0) it.command_byte = handled_cb[$urandom_range(10)];
      if ($urandom_range(2) == 0) it.param_byte = 8'h00;
      if ($urandom_range(3) == 0) it.button_mask = 16'h0001 << $urandom_range(15);
      send_item(it, 1'b0, to_reply(72'h0, 1'b0));
    end
  endtask

  // result side: check each taken item, then decide next pop
  initial begin
    out_item_t exp_b;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected result data %02h last %0b bad %0b", $time,
                   out_item.data_byte, out_item.last_byte, out_item.bad_command);
        end else begin
          exp_b = pending_bytes.pop_front();
          if (out_item.data_byte !== exp_b.data_byte) begin
            errors++;
            $display("%0t: data_byte expected %02h got %02h", $time,
                     exp_b.data_byte, out_item.data_byte);
          end
          if (out_item.last_byte !== exp_b.last_byte) begin
            errors++;
            $display("%0t: last_byte expected %0b got %0b", $time,
                     exp_b.last_byte, out_item.last_byte);
          end
          if (out_item.bad_command !== exp_b.bad_command) begin
            errors++;
            $display("%0t: bad_command expected %0b got %0b", $time,
                     exp_b.bad_command, out_item.bad_command);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    in_item_t it;
    rst_ni        = 1'b0;
    push          = 1'b0;
    in_item       = '0;
    errors        = 0;
    hold_cycles   = 0;
    send_idle_pct = 38;
    recv_idle_pct = 71;
    btn_word      = BUTTON_RESET;
    aim_x         = AIM_X_RESET;
    aim_y         = AIM_Y_RESET;
    cfg_mode      = 1'b0;
    handled_cb    = '{CB_INIT_PRESS, CB_QUERY_MASK, CB_READ_DATA, CB_CONFIG, CB_SET_MODE,
                      CB_QUERY_MODEL, CB_QUERY_ACT, CB_QUERY_COMB, CB_QUERY_MODE,
                      CB_VIB_MAP, CB_PRES_CFG};

    add_row(KIND_TRANSFER, CB_READ_DATA, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_63_5a_ff_ff_0d_01_88_00);
    add_row(KIND_TRANSFER, CB_CONFIG, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_63_5a_ff_ff_0d_01_88_00);
    add_row(KIND_TRANSFER, CB_CONFIG, 8'hff, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_63_5a_ff_ff_0d_01_88_00);
    add_row(KIND_TRANSFER, CB_CONFIG, 8'h01, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            BLANK_REPLY);
    add_row(KIND_TRANSFER, CB_CONFIG, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            BLANK_REPLY);
    add_row(KIND_TRANSFER, CB_INIT_PRESS, 8'h00, 16'hffff, AXIS_Y, 8'hff, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_02_00_00_5a);
    add_row(KIND_TRANSFER, CB_QUERY_MASK, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            BLANK_REPLY);
    add_row(KIND_TRANSFER, CB_SET_MODE, 8'hff, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            BLANK_REPLY);
    add_row(KIND_TRANSFER, CB_QUERY_MODEL, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_03_02_00_02_01_00);
    add_row(KIND_TRANSFER, CB_QUERY_ACT, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_01_02_00_0a);
    add_row(KIND_TRANSFER, CB_QUERY_ACT, 8'hff, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_01_01_01_14);
    add_row(KIND_TRANSFER, CB_QUERY_COMB, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_02_00_01_00);
    add_row(KIND_TRANSFER, CB_QUERY_MODE, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_00_04_00_00);
    add_row(KIND_TRANSFER, CB_QUERY_MODE, 8'h80, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_00_07_00_00);
    add_row(KIND_TRANSFER, CB_VIB_MAP, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_ff_ff_ff_ff);
    add_row(KIND_TRANSFER, CB_PRES_CFG, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_f3_5a_00_00_00_00_00_5a);
    // unhandled command bytes: single flagged item, state untouched
    add_row(KIND_TRANSFER, 8'h00, 8'hff, 16'hffff, 2'd3, 8'hff, 1'b1, 1'b1, 72'h0);
    add_row(KIND_TRANSFER, 8'hff, 8'h00, 16'hffff, 2'd3, 8'hff, 1'b1, 1'b1, 72'h0);
    add_row(KIND_TRANSFER, 8'h4e, 8'h01, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b1, 72'h0);
    add_row(KIND_PRESS, 8'hff, 8'hff, 16'hffff, 2'd3, 8'hff, 1'b0, 1'b0, 72'h0);
    add_row(KIND_AXIS, 8'hff, 8'hff, 16'hffff, AXIS_X, 8'hff, 1'b0, 1'b0, 72'h0);
    add_row(KIND_AXIS, 8'h00, 8'h00, 16'h0000, AXIS_Y, 8'h00, 1'b0, 1'b0, 72'h0);
    // axis selects 2 and 3 are ignored
    add_row(KIND_AXIS, 8'h00, 8'h00, 16'h0000, 2'd2, 8'h33, 1'b0, 1'b0, 72'h0);
    add_row(KIND_AXIS, 8'h00, 8'h00, 16'h0000, 2'd3, 8'h44, 1'b0, 1'b0, 72'h0);
    add_row(KIND_TRANSFER, CB_READ_DATA, 8'h00, 16'h0000, AXIS_X, 8'h00, 1'b1, 1'b0,
            72'hff_63_5a_00_00_ff_00_00_00);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].rep);

    // receiver holds off while transfers keep coming, so full must rise
    send_idle_pct = 0;
    hold_cycles   = 120;
    repeat (14) begin
      it              = in_item_t'(IN_W'({$urandom, $urandom}));
      it.cmd          = KIND_TRANSFER;
      it.command_byte = handled_cb[$urandom_range(10)];
      send_item(it, 1'b0, to_reply(72'h0, 1'b0));
    end
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);

    send_idle_pct = 38;
    recv_idle_pct = 71;
    run_random(118);
    send_idle_pct = 71;
    recv_idle_pct = 38;
    run_random(118);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(118);
    push <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
